[design/pump_current_soft_start_ramp_unit_macros.svh]
// Assertion macros used by the ramp unit checker.
`ifndef PUMP_CURRENT_SOFT_START_RAMP_UNIT_MACROS_SVH
`define PUMP_CURRENT_SOFT_START_RAMP_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/pcsr_pkg.sv]
// Package: shared types, codes and constants of the pump current ramp unit.
`default_nettype none

package pcsr_pkg;

  // Defaults for the top-level parameters
  localparam int CHANNELS_DEF  = 4;
  localparam int CODE_BITS_DEF = 16;

  // Fixed field widths
  localparam int CMD_W     = 2;
  localparam int CH_W      = 2;
  localparam int SET_W     = 12;
  localparam int SETTLE_W  = 10;
  localparam int STEP_W    = 8;
  localparam int SCALE_W   = 8;
  localparam int CFG_W     = 10;
  localparam int OUT_CH    = 4;
  localparam int OUT_CODE_W = 16;

  // setting * scale, then divide by ten through a reciprocal multiply
  localparam int PROD_W      = SET_W + SCALE_W;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP10 = 20'd838861;
  localparam int QUOT_W      = 17;

  // Register reset values
  localparam logic [SETTLE_W-1:0] SETTLE_RST = 10'd50;
  localparam logic [STEP_W-1:0]   RAMP_RST   = 8'd2;
  localparam logic [STEP_W-1:0]   OFFSTEP_RST = 8'd4;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 8'd148;

  typedef enum logic [1:0] {
    REG_SETTLE = 2'd0,
    REG_RAMP   = 2'd1,
    REG_OFF    = 2'd2,
    REG_SCALE  = 2'd3
  } reg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_ON      = 2'd1,
    CMD_OFF     = 2'd2,
    CMD_OFF_ALT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_TICK    = 2'd0,
    STAT_ACCEPT  = 2'd1,
    STAT_BUSY    = 2'd2,
    STAT_IGNORED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_ON_SETTLE  = 3'd1,
    PH_UP_FIRST   = 3'd2,
    PH_UP         = 3'd3,
    PH_DOWN_FIRST = 3'd4,
    PH_DOWN       = 3'd5,
    PH_OFF_SETTLE = 3'd6
  } phase_t;

  // Per-channel event strobes for one item
  typedef struct packed {
    logic tick;
    logic on;
    logic off;
  } chan_cmd_t;

  // Ramp timing registers seen by every channel
  typedef struct packed {
    logic [SETTLE_W-1:0] settle_ticks;
    logic [STEP_W-1:0]   ramp_step;
    logic [STEP_W-1:0]   off_step;
  } cfg_t;

endpackage

`default_nettype wire

[design/pcsr_chan.sv]
// One pump channel: enable, settle wait and DAC code ramp sequencer.
`default_nettype none

module pcsr_chan #(
  parameter int CODE_BITS = pcsr_pkg::CODE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pcsr_pkg::chan_cmd_t  cmd,
  input  wire pcsr_pkg::cfg_t       cfg,
  input  wire logic [CODE_BITS-1:0] target,
  output pcsr_pkg::status_t         status,
  output logic                      dac_wr,
  output logic                      en_nxt,
  output logic [CODE_BITS-1:0]      code_nxt
);
  import pcsr_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic                 off_r, off_nxt;
  logic                 en_r;
  logic [CODE_BITS-1:0] code_r;
  logic [CODE_BITS-1:0] tgt_r, tgt_nxt;
  logic [SETTLE_W-1:0]  wait_r, wait_nxt;

  logic [CODE_BITS-1:0] up_step, dn_step, diff;
  logic [SETTLE_W-1:0]  wait_dec;
  logic                 settle_zero;

  // Step sizes: first step is one, zero register acts as one
  always_comb begin
    if (phase_r == PH_UP_FIRST || cfg.ramp_step == '0) begin
      up_step = CODE_BITS'(1);
    end else begin
      up_step = CODE_BITS'(cfg.ramp_step);
    end
    if (phase_r == PH_DOWN_FIRST || cfg.off_step == '0) begin
      dn_step = CODE_BITS'(1);
    end else begin
      dn_step = CODE_BITS'(cfg.off_step);
    end
  end

  assign diff        = (tgt_r > code_r) ? (tgt_r - code_r) : (code_r - tgt_r);
  assign wait_dec    = (wait_r != '0) ? (wait_r - SETTLE_W'(1)) : wait_r;
  assign settle_zero = (cfg.settle_ticks == '0);

  // Next state of the channel
  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    code_nxt  = code_r;
    tgt_nxt   = tgt_r;
    wait_nxt  = wait_r;
    en_nxt    = en_r;
    if (cmd.tick) begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_ON_SETTLE: begin
          wait_nxt = wait_dec;
          if (wait_dec == '0) begin
            phase_nxt = PH_UP_FIRST;
          end
        end
        PH_UP_FIRST, PH_UP: begin
          if (up_step >= diff) begin
            code_nxt  = tgt_r;
            phase_nxt = PH_IDLE;
          end else begin
            code_nxt  = (tgt_r > code_r) ? (code_r + up_step) : (code_r - up_step);
            phase_nxt = PH_UP;
          end
        end
        PH_DOWN_FIRST, PH_DOWN: begin
          if (code_r > dn_step) begin
            code_nxt  = code_r - dn_step;
            phase_nxt = PH_DOWN;
          end else begin
            code_nxt = '0;
            wait_nxt = cfg.settle_ticks;
            if (settle_zero) begin
              en_nxt    = 1'b0;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_OFF_SETTLE;
            end
          end
        end
        PH_OFF_SETTLE: begin
          wait_nxt = wait_dec;
          if (wait_dec == '0) begin
            en_nxt    = 1'b0;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end else if (cmd.on && phase_r == PH_IDLE) begin
      tgt_nxt = target;
      if (off_r) begin
        off_nxt   = 1'b0;
        en_nxt    = 1'b1;
        wait_nxt  = cfg.settle_ticks;
        phase_nxt = settle_zero ? PH_UP_FIRST : PH_ON_SETTLE;
      end else if (target != code_r) begin
        phase_nxt = PH_UP_FIRST;
      end
    end else if (cmd.off && phase_r == PH_IDLE && !off_r) begin
      off_nxt   = 1'b1;
      tgt_nxt   = '0;
      phase_nxt = PH_DOWN_FIRST;
    end
  end

  // Outputs: command status and DAC write strobe
  always_comb begin
    dac_wr = 1'b0;
    status = STAT_ACCEPT;
    if (cmd.tick) begin
      status = STAT_TICK;
      dac_wr = (phase_r == PH_UP_FIRST) || (phase_r == PH_UP) ||
               (phase_r == PH_DOWN_FIRST) || (phase_r == PH_DOWN);
    end else if (phase_r != PH_IDLE) begin
      status = STAT_BUSY;
    end else if (cmd.off && off_r) begin
      status = STAT_IGNORED;
    end
  end

  // Hold channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      off_r   <= 1'b1;
      en_r    <= 1'b0;
      code_r  <= '0;
      tgt_r   <= '0;
      wait_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      en_r    <= en_nxt;
      code_r  <= code_nxt;
      tgt_r   <= tgt_nxt;
      wait_r  <= wait_nxt;
    end
  end

endmodule

`default_nettype wire

[design/pump_current_soft_start_ramp_unit.sv]
// Top level: soft-start DAC current ramp sequencer for the laser pump channels.
// Pipeline: product stage, then update stage, which fills the result register.
// Throughput: one item per cycle; both stages hold together while the result is stalled.
// Reset: synchronous, active low; channels off, codes zero, registers to defaults.
`default_nettype none

module pump_current_soft_start_ramp_unit #(
  parameter int CHANNELS  = pcsr_pkg::CHANNELS_DEF,
  parameter int CODE_BITS = pcsr_pkg::CODE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [1:0]                   cfg_idx,
  input  wire logic [pcsr_pkg::CFG_W-1:0]   cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [pcsr_pkg::CMD_W-1:0]   in_command,
  input  wire logic [pcsr_pkg::CH_W-1:0]    in_channel,
  input  wire logic [pcsr_pkg::SET_W-1:0]   in_current_setting,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_status,
  output logic [15:0]                       out_dac_code_0,
  output logic [15:0]                       out_dac_code_1,
  output logic [15:0]                       out_dac_code_2,
  output logic [15:0]                       out_dac_code_3,
  output logic [3:0]                        out_dac_write_mask,
  output logic [3:0]                        out_enable_mask,
  output logic                              out_laser_led
);
  import pcsr_pkg::*;

  localparam int FULL_W = PROD_W + RECIP_W;
  localparam logic [QUOT_W-1:0] CODE_MAX_Q = QUOT_W'((1 << CODE_BITS) - 1);

  // Configuration registers
  cfg_t               cfg_r;
  logic [SCALE_W-1:0] scale_r;

  // Stage one: registered item and setting product
  logic              s1_vld_r;
  cmd_t              s1_cmd_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic [PROD_W-1:0] s1_prod_r;
  logic              in_acc, out_rdy, s1_adv;

  // Target calculation
  logic [FULL_W-1:0]    quot_full;
  logic [QUOT_W-1:0]    quot;
  logic [CODE_BITS-1:0] target;

  // Channel array
  chan_cmd_t            chan_cmd  [CHANNELS];
  status_t              chan_stat [CHANNELS];
  logic                 chan_wr   [CHANNELS];
  logic                 chan_en   [CHANNELS];
  logic [CODE_BITS-1:0] chan_code [CHANNELS];

  // Result assembly and result register
  status_t     status_cur;
  logic [15:0] code_cur [OUT_CH];
  logic [3:0]  wmask_cur, emask_cur;
  logic        out_vld_r;
  logic [1:0]  out_status_r;
  logic [15:0] out_code_r [OUT_CH];
  logic [3:0]  out_wmask_r, out_emask_r;
  logic        out_led_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks <= SETTLE_RST;
      cfg_r.ramp_step    <= RAMP_RST;
      cfg_r.off_step     <= OFFSTEP_RST;
      scale_r            <= SCALE_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_SETTLE: cfg_r.settle_ticks <= cfg_wr_data;
        REG_RAMP:   cfg_r.ramp_step    <= cfg_wr_data[STEP_W-1:0];
        REG_OFF:    cfg_r.off_step     <= cfg_wr_data[STEP_W-1:0];
        REG_SCALE:  scale_r            <= cfg_wr_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: both stages advance when the result register frees up
  assign out_rdy  = !out_vld_r || !out_stall;
  assign s1_adv   = s1_vld_r && out_rdy;
  assign in_stall = s1_vld_r && !out_rdy;
  assign in_acc   = in_valid && !in_stall;

  // Stage one: capture item, form setting times scale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (out_rdy) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= cmd_t'(in_command);
      s1_ch_r   <= in_channel;
      s1_prod_r <= PROD_W'(in_current_setting) * PROD_W'(scale_r);
    end
  end

  // Divide by ten through the reciprocal, saturate to the code range
  assign quot_full = FULL_W'(s1_prod_r) * FULL_W'(RECIP10);
  assign quot      = quot_full[RECIP_SHIFT +: QUOT_W];
  assign target    = (quot > CODE_MAX_Q) ? CODE_MAX_Q[CODE_BITS-1:0] : quot[CODE_BITS-1:0];

  // Channel sequencers
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic sel;
    assign sel = (int'(s1_ch_r) == c);
    assign chan_cmd[c].tick = s1_adv && (s1_cmd_r == CMD_TICK);
    assign chan_cmd[c].on   = s1_adv && sel && (s1_cmd_r == CMD_ON);
    assign chan_cmd[c].off  = s1_adv && sel &&
                              (s1_cmd_r == CMD_OFF || s1_cmd_r == CMD_OFF_ALT);

    pcsr_chan #(
      .CODE_BITS (CODE_BITS)
    ) u_chan (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (chan_cmd[c]),
      .cfg      (cfg_r),
      .target   (target),
      .status   (chan_stat[c]),
      .dac_wr   (chan_wr[c]),
      .en_nxt   (chan_en[c]),
      .code_nxt (chan_code[c])
    );
  end

  // Pick the status of the addressed channel, or the tick status for a tick
  always_comb begin
    status_cur = STAT_IGNORED;
    if (s1_cmd_r == CMD_TICK) begin
      status_cur = STAT_TICK;
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (int'(s1_ch_r) == c) begin
          status_cur = chan_stat[c];
        end
      end
    end
  end

  // Map channels onto the four reported lanes, zero for missing ones
  for (genvar j = 0; j < OUT_CH; j++) begin : g_lane
    if (j < CHANNELS) begin : g_used
      assign code_cur[j]  = 16'(chan_code[j]);
      assign wmask_cur[j] = chan_wr[j];
      assign emask_cur[j] = chan_en[j];
    end else begin : g_none
      assign code_cur[j]  = '0;
      assign wmask_cur[j] = 1'b0;
      assign emask_cur[j] = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= status_cur;
      out_code_r   <= code_cur;
      out_wmask_r  <= wmask_cur;
      out_emask_r  <= emask_cur;
      out_led_r    <= chan_en[0];
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_status_r;
  assign out_dac_code_0     = out_code_r[0];
  assign out_dac_code_1     = out_code_r[1];
  assign out_dac_code_2     = out_code_r[2];
  assign out_dac_code_3     = out_code_r[3];
  assign out_dac_write_mask = out_wmask_r;
  assign out_enable_mask    = out_emask_r;
  assign out_laser_led      = out_led_r;

endmodule

`default_nettype wire

[design/pcsr_checker.sv]
// Port checker for the pump current ramp unit, bound to the top level.
`default_nettype none

`include "pump_current_soft_start_ramp_unit_macros.svh"

module pcsr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_dac_code_0,
  input wire logic [3:0]  out_dac_write_mask,
  input wire logic [3:0]  out_enable_mask,
  input wire logic        out_laser_led
);
  import pcsr_pkg::*;

  // A stalled item stays put
  `PCSR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_dac_code_0), "stalled item changed")

  // The lamp follows channel 0 enable
  `PCSR_ASSERT_IMP(a_led_follows, out_valid, out_laser_led == out_enable_mask[0], "led differs from channel 0 enable")

  // Only ticks write the DACs
  `PCSR_ASSERT_IMP(a_cmd_no_write, out_valid && out_status != STAT_TICK, out_dac_write_mask == 4'd0, "command item shows DAC writes")

endmodule

bind pump_current_soft_start_ramp_unit pcsr_checker u_pcsr_checker (.*);

`default_nettype wire
